[src/session_slot_table_assert.svh]
// ----------------------------------------------------------------------------
// session_slot_table_assert.svh
// Assertion macros shared by the session slot table sources. Each macro
// samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SESSION_SLOT_TABLE_ASSERT_SVH
`define SESSION_SLOT_TABLE_ASSERT_SVH

`ifndef SYNTH
// Checks the consequent in the same cycle as the antecedent.
`define SST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Checks the consequent in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SST_ASSERT_NOW(label, ante, cons, msg)
`define SST_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[src/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg
// Types and constants shared by the session slot table modules.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Request codes carried by req_type.
  typedef enum logic [2:0] {
    REQ_ADD         = 3'd0,
    REQ_REMOVE      = 3'd1,
    REQ_FIND_ID     = 3'd2,
    REQ_FIND_HANDLE = 3'd3,
    REQ_TOUCH       = 3'd4,
    REQ_TICK        = 3'd5
  } req_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN,
    ST_EMIT
  } fsm_t;

  // What an accepted request turns into.
  typedef enum logic [1:0] {
    DSP_REFUSE,
    DSP_ALLOC,
    DSP_SCAN
  } dsp_t;

  // Reported slot states.
  localparam logic [1:0] SLOT_FREE       = 2'd0;
  localparam logic [1:0] SLOT_CONNECTING = 2'd1;
  localparam logic [1:0] SLOT_KICKED     = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_MAX_ACTIVE   = 1'b0;
  localparam logic CFG_IDLE_TIMEOUT = 1'b1;

  // Configuration reset values.
  localparam logic [4:0]  MAX_ACTIVE_RST   = 5'd16;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd30000;

  // One stored slot entry; liveness is held separately in flops.
  typedef struct packed {
    logic        kicked;
    logic [15:0] handle;
    logic [15:0] idle;
  } entry_t;

  // Verdict of the shared evaluation unit for one entry.
  typedef struct packed {
    logic   hit;
    logic   we;
    entry_t entry;
  } sst_eval_t;

  // Write command from the sequencer to the slot store.
  typedef struct packed {
    logic mem_we;
    logic live_set;
    logic live_clr;
  } sst_cmd_t;

endpackage

[src/sst_store.sv]
// ----------------------------------------------------------------------------
// sst_store
// Slot storage: a single-port-write entry memory with a registered read, and
// a live flag per slot that reset clears.
// ----------------------------------------------------------------------------
module sst_store #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(SLOTS)-1:0]      rd_addr,
  output sst_pkg::entry_t               rd_data,
  input  sst_pkg::sst_cmd_t             cmd,
  input  logic [$clog2(SLOTS)-1:0]      wr_addr,
  input  sst_pkg::entry_t               wr_data,
  output logic [SLOTS-1:0]              live
);
  import sst_pkg::*;

  entry_t mem [SLOTS];

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Live flags; a slot that is not live reads as free.
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (cmd.live_set) begin
      live[wr_addr] <= 1'b1;
    end else if (cmd.live_clr) begin
      live[wr_addr] <= 1'b0;
    end
  end

endmodule

[src/sst_eval.sv]
// ----------------------------------------------------------------------------
// sst_eval
// Shared evaluation unit: one handle compare and one saturating idle-time
// add, applied to the entry that the sequencer has just read.
// ----------------------------------------------------------------------------
module sst_eval (
  input  sst_pkg::req_t     req,
  input  sst_pkg::entry_t   entry_in,
  input  logic              live,
  input  logic [15:0]       handle,
  input  logic [15:0]       elapsed,
  input  logic [15:0]       timeout,
  output sst_pkg::sst_eval_t result
);
  import sst_pkg::*;

  logic [16:0] sum;

  // Idle time after a tick, before saturation.
  assign sum = {1'b0, entry_in.idle} + {1'b0, elapsed};

  // Decide on a match and on the updated entry.
  always_comb begin
    result       = '0;
    result.entry = entry_in;
    case (req)
      REQ_REMOVE, REQ_FIND_ID: begin
        result.hit = 1'b1;
      end
      REQ_TOUCH: begin
        result.hit        = 1'b1;
        result.we         = 1'b1;
        result.entry.idle = '0;
      end
      REQ_FIND_HANDLE: begin
        result.hit = live && (entry_in.handle == handle);
      end
      REQ_TICK: begin
        result.we = live;
        if (sum > {1'b0, timeout}) begin
          result.entry.kicked = 1'b1;
          result.entry.idle   = timeout;
        end else begin
          result.entry.idle = sum[15:0];
        end
      end
      default: begin
        result.hit = 1'b0;
      end
    endcase
  end

endmodule

[src/session_slot_table.sv]
// ----------------------------------------------------------------------------
// session_slot_table
// Fixed table of session slots with add, remove, lookup, touch and idle
// aging, run by a small sequencer over one shared evaluation unit.
// ----------------------------------------------------------------------------
// One request is handled at a time. The slot memory has one read port, so a
// lookup by handle and a tick walk the table one entry per cycle. An add
// scans the live flags one slot per cycle from slot 0 and claims the lowest
// free position. Remove, touch and lookup by identifier read one entry; a
// refused or unknown request reads none. The result sits in an output
// register, and the next request is taken in the cycle after the result is
// loaded there. Configuration writes take effect at once and are expected
// only while no request is in flight.
`include "session_slot_table_assert.svh"

module session_slot_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [15:0] conn_handle,
  input  logic [3:0]  slot_index,
  input  logic [7:0]  player_key,
  input  logic [15:0] elapsed_ms,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [3:0]  found_slot,
  output logic [4:0]  found_id,
  output logic [15:0] found_handle,
  output logic [1:0]  found_state,
  output logic [4:0]  active_count
);
  import sst_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  fsm_t            state;
  fsm_t            state_next;
  logic [4:0]      max_active;
  logic [15:0]     idle_timeout_ms;
  logic [CW-1:0]   live_count;

  // Captured request.
  req_t            req_r;
  logic [15:0]     handle_r;
  logic [15:0]     elapsed_r;
  logic            single_r;

  // Scan pointers: ptr issues reads, ev_ptr names the entry being evaluated.
  logic [SW-1:0]   ptr;
  logic            issuing;
  logic            ev_vld;
  logic [SW-1:0]   ev_ptr;
  logic            ev_last;
  logic            issue_last;
  logic            scan_done;

  // Pending result.
  logic            res_status;
  logic            res_hit;
  logic [SW-1:0]   res_slot;
  logic [15:0]     res_handle;
  logic [1:0]      res_state;
  logic [SW+4:0]   res_ext;
  logic [SW+4:0]   id_ext;
  logic            emit_load;

  // Request decode.
  dsp_t            dsp;
  logic [SW-1:0]   start_ptr;
  logic            start_single;
  logic [SW+4:0]   idx_ext;
  logic            idx_ok;
  logic [SW+8:0]   key_ext;
  logic [SW+8:0]   key_sub;
  logic            key_ok;
  logic            can_add;

  // Store and evaluation unit connections.
  entry_t          rd_data;
  sst_cmd_t        cmd;
  logic [SW-1:0]   wr_addr;
  entry_t          wr_data;
  logic [SLOTS-1:0] live;
  sst_eval_t       ev;

  sst_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(ptr),
    .rd_data(rd_data),
    .cmd    (cmd),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .live   (live)
  );

  sst_eval u_eval (
    .req     (req_r),
    .entry_in(rd_data),
    .live    (live[ev_ptr]),
    .handle  (handle_r),
    .elapsed (elapsed_r),
    .timeout (idle_timeout_ms),
    .result  (ev)
  );

  assign in_stall = (state != ST_IDLE);

  // Range checks on the addressed slot and on the identifier.
  assign idx_ext = (SW + 5)'(slot_index);
  assign idx_ok  = idx_ext < (SW + 5)'(SLOTS);
  assign key_ext = (SW + 9)'(player_key);
  assign key_sub = key_ext - (SW + 9)'(1);
  assign key_ok  = (player_key != 8'd0) && (key_ext <= (SW + 9)'(SLOTS));
  assign can_add = ((CW + 5)'(live_count) < (CW + 5)'(max_active)) &&
                   (live_count != CW'(SLOTS));

  // Decide how an incoming request is served.
  always_comb begin
    dsp          = DSP_REFUSE;
    start_ptr    = '0;
    start_single = 1'b0;
    case (req_type)
      REQ_ADD: begin
        if (can_add) begin
          dsp = DSP_ALLOC;
        end
      end
      REQ_REMOVE, REQ_TOUCH: begin
        start_ptr    = idx_ext[SW-1:0];
        start_single = 1'b1;
        if (idx_ok && live[idx_ext[SW-1:0]]) begin
          dsp = DSP_SCAN;
        end
      end
      REQ_FIND_ID: begin
        start_ptr    = key_sub[SW-1:0];
        start_single = 1'b1;
        if (key_ok && live[key_sub[SW-1:0]]) begin
          dsp = DSP_SCAN;
        end
      end
      REQ_FIND_HANDLE, REQ_TICK: begin
        dsp = DSP_SCAN;
      end
      default: begin
        dsp = DSP_REFUSE;
      end
    endcase
  end

  assign issue_last = single_r || (ptr == SW'(SLOTS - 1));
  assign scan_done  = ev_vld && (ev.hit || ev_last);
  assign emit_load  = (state == ST_EMIT) && (!out_valid || !out_stall);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (dsp)
            DSP_ALLOC: state_next = ST_ALLOC;
            DSP_SCAN:  state_next = ST_SCAN;
            default:   state_next = ST_EMIT;
          endcase
        end
      end
      ST_ALLOC: begin
        if (!live[ptr]) begin
          state_next = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Store write commands.
  always_comb begin
    cmd     = '0;
    wr_addr = ev_ptr;
    wr_data = ev.entry;
    case (state)
      ST_ALLOC: begin
        wr_addr = ptr;
        wr_data = '{kicked: 1'b0, handle: handle_r, idle: 16'd0};
        if (!live[ptr]) begin
          cmd.mem_we   = 1'b1;
          cmd.live_set = 1'b1;
        end
      end
      ST_SCAN: begin
        if (ev_vld) begin
          cmd.mem_we   = ev.we;
          cmd.live_clr = ev.hit && (req_r == REQ_REMOVE);
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Control registers: sequencer, scan pointers, count and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      max_active      <= MAX_ACTIVE_RST;
      idle_timeout_ms <= IDLE_TIMEOUT_RST;
      live_count      <= '0;
      ptr             <= '0;
      issuing         <= 1'b0;
      ev_vld          <= 1'b0;
      ev_ptr          <= '0;
      ev_last         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        if (cfg_index == CFG_MAX_ACTIVE) begin
          max_active <= cfg_data[4:0];
        end else begin
          idle_timeout_ms <= cfg_data;
        end
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ptr     <= start_ptr;
            issuing <= 1'b1;
            ev_vld  <= 1'b0;
          end
        end
        ST_ALLOC: begin
          if (!live[ptr]) begin
            live_count <= live_count + CW'(1);
          end else begin
            ptr <= ptr + SW'(1);
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle; evaluate it the cycle after.
          if (issuing) begin
            ev_vld  <= 1'b1;
            ev_ptr  <= ptr;
            ev_last <= issue_last;
            if (issue_last) begin
              issuing <= 1'b0;
            end else begin
              ptr <= ptr + SW'(1);
            end
          end else begin
            ev_vld <= 1'b0;
          end
          if (scan_done) begin
            issuing <= 1'b0;
            ev_vld  <= 1'b0;
            if (ev.hit && (req_r == REQ_REMOVE)) begin
              live_count <= live_count - CW'(1);
            end
          end
        end
        default: begin
          issuing <= 1'b0;
        end
      endcase

      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res_ext = (SW + 5)'(res_slot);
  assign id_ext  = res_ext + (SW + 5)'(1);

  // Payload registers: captured request, pending result and output fields.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_r      <= req_t'(req_type);
          handle_r   <= conn_handle;
          elapsed_r  <= elapsed_ms;
          single_r   <= start_single;
          res_status <= 1'b1;
          res_hit    <= 1'b0;
          res_slot   <= '0;
          res_handle <= '0;
          res_state  <= SLOT_FREE;
        end
      end
      ST_ALLOC: begin
        if (!live[ptr]) begin
          res_status <= 1'b0;
          res_hit    <= 1'b1;
          res_slot   <= ptr;
          res_handle <= handle_r;
          res_state  <= SLOT_CONNECTING;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (ev.hit) begin
            res_status <= 1'b0;
            res_hit    <= 1'b1;
            res_slot   <= ev_ptr;
            res_handle <= rd_data.handle;
            if (req_r == REQ_REMOVE) begin
              res_state <= SLOT_FREE;
            end else if (ev.entry.kicked) begin
              res_state <= SLOT_KICKED;
            end else begin
              res_state <= SLOT_CONNECTING;
            end
          end else begin
            // A tick always succeeds; a handle lookup that ran out did not.
            res_status <= (req_r != REQ_TICK);
          end
        end
      end
      default: begin
        res_status <= res_status;
      end
    endcase

    if (emit_load) begin
      status       <= res_status;
      found_slot   <= res_hit ? res_ext[3:0] : 4'd0;
      found_id     <= res_hit ? id_ext[4:0] : 5'd0;
      found_handle <= res_handle;
      found_state  <= res_state;
      active_count <= 5'(live_count);
    end
  end

  // The count of live slots tracks the live flags and never passes the size.
  `SST_ASSERT_NOW(a_count_flags, 1'b1, live_count == CW'($countones(live)), "live count differs from live flags")
  `SST_ASSERT_NOW(a_count_bound, 1'b1, live_count <= CW'(SLOTS), "live count above table size")
  // A slot claimed by an add is live in the next cycle.
  `SST_ASSERT_NEXT(a_alloc_live, (state == ST_ALLOC) && !live[ptr], live[$past(ptr)], "claimed slot not live")
  // A result only appears after the sequencer has finished a request.
  `SST_ASSERT_NOW(a_out_from_emit, $rose(out_valid), $past(state) == ST_EMIT, "result raised outside emit")

endmodule
